// File: rtl/vn_pkg.sv
// Shared constants and result type for the 3D vector normaliser.
package vn_pkg;

  localparam int unsigned OUT_W   = 32;
  localparam int unsigned LANES   = 3;
  localparam int unsigned ENTRY_W = LANES * OUT_W + 1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

  typedef struct packed {
    logic             status;
    logic [OUT_W-1:0] uz;
    logic [OUT_W-1:0] uy;
    logic [OUT_W-1:0] ux;
  } result_t;

endpackage

// File: rtl/vn_sqrt_cell.sv
// One digit cell of the pipelined integer square root (one root bit per cell).
module vn_sqrt_cell #(
  parameter int unsigned W = 32
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [2*W-1:0]   x_i,
  input  logic [W+1:0]     rem_i,
  input  logic [W-1:0]     root_i,
  output logic [2*W-1:0]   x_o,
  output logic [W+1:0]     rem_o,
  output logic [W-1:0]     root_o
);
  import vn_pkg::*;

  logic [W+1:0]   r2;
  logic [W+1:0]   trial;
  logic [2*W-1:0] x_d;
  logic [W+1:0]   rem_d;
  logic [W-1:0]   root_d;
  logic [2*W-1:0] x_q;
  logic [W+1:0]   rem_q;
  logic [W-1:0]   root_q;

  always_comb begin
    // bring down the next two radicand bits
    r2    = {rem_i[W-1:0], x_i[2*W-1:2*W-2]};
    trial = {root_i, 2'b01};
    x_d   = {x_i[2*W-3:0], 2'b00};
    if (r2 >= trial) begin
      rem_d  = r2 - trial;
      root_d = {root_i[W-2:0], 1'b1};
    end else begin
      rem_d  = r2;
      root_d = {root_i[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign x_o    = x_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

// File: rtl/vn_div_cell.sv
// One restoring-division cell: one quotient bit per cell for one component.
module vn_div_cell #(
  parameter int unsigned W  = 32,
  parameter int unsigned QW = 31
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [W-1:0]  rem_i,
  input  logic          bit_i,
  input  logic [W-1:0]  norm_i,
  input  logic [QW-1:0] quo_i,
  output logic [W-1:0]  rem_o,
  output logic [W-1:0]  norm_o,
  output logic [QW-1:0] quo_o
);
  import vn_pkg::*;

  logic [W:0]    t;
  logic [W:0]    diff;
  logic [W-1:0]  rem_d;
  logic [QW-1:0] quo_d;
  logic [W-1:0]  rem_q;
  logic [W-1:0]  norm_q;
  logic [QW-1:0] quo_q;

  always_comb begin
    t    = {rem_i, bit_i};
    diff = t - {1'b0, norm_i};
    if (t >= {1'b0, norm_i}) begin
      rem_d = diff[W-1:0];
      quo_d = {quo_i[QW-2:0], 1'b1};
    end else begin
      rem_d = t[W-1:0];
      quo_d = {quo_i[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      norm_q <= norm_i;
      quo_q  <= quo_d;
    end
  end

  assign rem_o  = rem_q;
  assign norm_o = norm_q;
  assign quo_o  = quo_q;

endmodule

// File: rtl/vector3_normalizer.sv
// Pipeline from input transaction to output valid: 3 front stages (the first loads on the
// accepting edge), one root cell per root bit, a check stage, one divider cell per quotient
// bit, and the output buffer. Throughput: one transaction per cycle while in_stall_o is low;
// a two-entry output buffer absorbs output stalls, and in_stall_o rises when it is full.
// Reset clears all valid flags, empties the buffer, and sets min_norm to 1.
module vector3_normalizer #(
  parameter int unsigned COMPONENT_WIDTH = 32,
  parameter int unsigned FRACTION_BITS   = 30
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        min_norm_we_i,
  input  logic [31:0] min_norm_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] vx_i,
  input  logic [31:0] vy_i,
  input  logic [31:0] vz_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] ux_o,
  output logic [31:0] uy_o,
  output logic [31:0] uz_o,
  output logic        status_o
);
  import vn_pkg::*;

  localparam int unsigned CW = COMPONENT_WIDTH;
  localparam int unsigned SW = 2 * CW;
  localparam int unsigned QW = FRACTION_BITS + 1;
  localparam int unsigned N  = 3 + CW + 1 + QW;
  localparam int unsigned SIDE_W = 3 * CW + 3;

  logic        en;
  logic [1:0]  cnt_q;
  logic [31:0] min_norm_q;
  logic [N-1:0] vld_q;

  assign en         = (cnt_q != 2'd2);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_norm_q <= 32'd1;
    end else if (min_norm_we_i) begin
      min_norm_q <= min_norm_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[N-2:0], in_valid_i};
    end
  end

  // front: magnitudes, squares, sum
  logic [CW-1:0] raw [3];
  logic [CW-1:0] s0_mag_q [3];
  logic          s0_neg_q [3];
  logic [SW-1:0] s1_sq_q  [3];
  logic [CW-1:0] s1_mag_q [3];
  logic          s1_neg_q [3];
  logic [SW-1:0] s2_sum_q;
  logic [CW-1:0] s2_mag_q [3];
  logic          s2_neg_q [3];

  assign raw[0] = vx_i[CW-1:0];
  assign raw[1] = vy_i[CW-1:0];
  assign raw[2] = vz_i[CW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s0_neg_q[i] <= raw[i][CW-1];
        s0_mag_q[i] <= raw[i][CW-1] ? (~raw[i] + 1'b1) : raw[i];
        s1_sq_q[i]  <= SW'(s0_mag_q[i]) * SW'(s0_mag_q[i]);
        s1_mag_q[i] <= s0_mag_q[i];
        s1_neg_q[i] <= s0_neg_q[i];
        s2_mag_q[i] <= s1_mag_q[i];
        s2_neg_q[i] <= s1_neg_q[i];
      end
      s2_sum_q <= s1_sq_q[0] + s1_sq_q[1] + s1_sq_q[2];
    end
  end

  // square root chain
  logic [SW-1:0]     sx_w    [CW+1];
  logic [CW+1:0]     srem_w  [CW+1];
  logic [CW-1:0]     sroot_w [CW+1];
  logic [SIDE_W-1:0] sside_q [CW];

  assign sx_w[0]    = s2_sum_q;
  assign srem_w[0]  = '0;
  assign sroot_w[0] = '0;

  for (genvar c = 0; c < CW; c++) begin : g_sqrt
    vn_sqrt_cell #(.W(CW)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .x_i    (sx_w[c]),
      .rem_i  (srem_w[c]),
      .root_i (sroot_w[c]),
      .x_o    (sx_w[c+1]),
      .rem_o  (srem_w[c+1]),
      .root_o (sroot_w[c+1])
    );
    if (c == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en) begin
          sside_q[c] <= {s2_neg_q[2], s2_neg_q[1], s2_neg_q[0],
                         s2_mag_q[2], s2_mag_q[1], s2_mag_q[0]};
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk_i) begin
        if (en) begin
          sside_q[c] <= sside_q[c-1];
        end
      end
    end
  end

  // threshold check
  logic [CW-1:0] chk_norm_q;
  logic [CW-1:0] chk_mag_q [3];
  logic [2:0]    chk_neg_q;
  logic          chk_short_q;
  logic [SIDE_W-1:0] sside_last;

  assign sside_last = sside_q[CW-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      chk_norm_q  <= sroot_w[CW];
      chk_short_q <= (sroot_w[CW] == '0) || (32'(sroot_w[CW]) < min_norm_q)
                     ? STATUS_SHORT : STATUS_OK;
      chk_neg_q   <= sside_last[SIDE_W-1 -: 3];
      for (int i = 0; i < 3; i++) begin
        chk_mag_q[i] <= sside_last[i*CW +: CW];
      end
    end
  end

  // division chains, one per component
  logic [CW-1:0] drem_w  [3][QW+1];
  logic [CW-1:0] dnorm_w [3][QW+1];
  logic [QW-1:0] dquo_w  [3][QW+1];
  logic [3:0]    dside_q [QW];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign drem_w[l][0]  = chk_mag_q[l] >> 1;
    assign dnorm_w[l][0] = chk_norm_q;
    assign dquo_w[l][0]  = '0;
    for (genvar c = 0; c < QW; c++) begin : g_div
      vn_div_cell #(.W(CW), .QW(QW)) u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .rem_i  (drem_w[l][c]),
        .bit_i  ((c == 0) ? chk_mag_q[l][0] : 1'b0),
        .norm_i (dnorm_w[l][c]),
        .quo_i  (dquo_w[l][c]),
        .rem_o  (drem_w[l][c+1]),
        .norm_o (dnorm_w[l][c+1]),
        .quo_o  (dquo_w[l][c+1])
      );
    end
  end

  for (genvar c = 0; c < QW; c++) begin : g_dside
    if (c == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en) begin
          dside_q[c] <= {chk_short_q, chk_neg_q};
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk_i) begin
        if (en) begin
          dside_q[c] <= dside_q[c-1];
        end
      end
    end
  end

  // result formatting
  result_t          res;
  logic [OUT_W-1:0] mag_out [3];
  logic [OUT_W-1:0] comp    [3];
  logic [3:0]       dside_last;

  assign dside_last = dside_q[QW-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_out[i] = OUT_W'(dquo_w[i][QW]);
      if (dside_last[3] == STATUS_SHORT) begin
        comp[i] = '0;
      end else if (dside_last[i]) begin
        comp[i] = ~mag_out[i] + 1'b1;
      end else begin
        comp[i] = mag_out[i];
      end
    end
    res.status = dside_last[3];
    res.ux     = comp[0];
    res.uy     = comp[1];
    res.uz     = comp[2];
  end

  // two-entry output buffer
  result_t head_q;
  result_t tail_q;
  logic    push;
  logic    pop;

  assign push = vld_q[N-1] && en;
  assign pop  = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (push && !pop) begin
      cnt_q <= cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && !pop) begin
      if (cnt_q == 2'd0) begin
        head_q <= res;
      end else begin
        tail_q <= res;
      end
    end else if (pop && !push) begin
      head_q <= tail_q;
    end else if (push && pop) begin
      head_q <= res;
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign ux_o        = head_q.ux;
  assign uy_o        = head_q.uy;
  assign uz_o        = head_q.uz;
  assign status_o    = head_q.status;

  localparam logic signed [OUT_W-1:0] UNIT_POS = OUT_W'(1) << FRACTION_BITS;
  localparam logic signed [OUT_W-1:0] UNIT_NEG = -UNIT_POS;

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("output buffer count overflow");

  a_short_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_SHORT |-> ux_o == '0 && uy_o == '0 && uz_o == '0)
    else $error("short vector with non-zero components");

  a_unit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_OK |->
      $signed(ux_o) <= UNIT_POS && $signed(ux_o) >= UNIT_NEG)
    else $error("unit component out of range");

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |=> cnt_q != 2'd3 && $past(!push))
    else $error("push into full output buffer");

endmodule
